@@ sv/tccs_pkg.sv @@
package tccs_pkg;

  // Default screen geometry
  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 25;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned OutColW = 7;
  localparam int unsigned OutRowW = 5;

  localparam logic [CharW-1:0]  NewlineCode  = 8'd10;
  localparam logic [ColorW-1:0] ColorDefault = 8'd7;

  // Request type codes
  localparam logic ReqPut  = 1'b0;
  localparam logic ReqRead = 1'b1;

  // Register index of the colour register
  localparam logic RegTextColor = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept_put;   // put item taken this cycle
    logic accept_read;  // read item taken this cycle
    logic cnt_clr;      // restart the sweep counter
    logic copy_rd;      // read one source cell of the scroll copy
    logic zero_wr;      // write zero at the sweep counter
    logic scroll_done;  // last cell of a scroll cleared
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scroll_need;  // a put now would move past the last row
    logic cnt_copy_last;
    logic cnt_cell_last;
  } status_t;

endpackage

@@ sv/tccs_ctrl.sv @@
module tccs_ctrl import tccs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    req_type_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  typedef enum logic [4:0] {
    StInit  = 5'b00001,
    StIdle  = 5'b00010,
    StCopy  = 5'b00100,
    StDrain = 5'b01000,
    StWipe  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Decode commands and the next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StInit: begin
        cmd_o.zero_wr = 1'b1;
        if (status_i.cnt_cell_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          if (req_type_i == ReqRead) begin
            cmd_o.accept_read = 1'b1;
          end else begin
            cmd_o.accept_put = 1'b1;
            if (status_i.scroll_need) begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = StCopy;
            end
          end
        end
      end
      StCopy: begin
        cmd_o.copy_rd = 1'b1;
        if (status_i.cnt_copy_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StWipe;
      end
      StWipe: begin
        cmd_o.zero_wr = 1'b1;
        if (status_i.cnt_cell_last) begin
          cmd_o.scroll_done = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StInit;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  // A scrolling put holds the block busy on the next cycle
  a_scroll_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept_put && status_i.scroll_need) |=> busy)
    else $error("scroll did not hold busy");

  // The copy pass is always followed by the drain cycle
  a_copy_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy && status_i.cnt_copy_last) |=> state_q == StDrain)
    else $error("copy pass did not drain");

  // Exactly one state bit is set
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

@@ sv/tccs_dp.sv @@
module tccs_dp import tccs_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DefColumns,
  parameter int unsigned SCREEN_ROWS    = DefRows
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [ColorW-1:0]  text_color_i,
  input  logic [CharW-1:0]   char_code_i,
  input  logic [IndexW-1:0]  read_index_i,
  output logic               done_o,
  output logic [OutColW-1:0] cursor_col_o,
  output logic [OutRowW-1:0] cursor_row_o,
  output logic [CharW-1:0]   cell_char_o,
  output logic [ColorW-1:0]  cell_color_o,
  output logic               scrolled_o
);

  localparam int unsigned CellCount = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned CopyCount = SCREEN_COLUMNS * (SCREEN_ROWS - 1);
  localparam int unsigned CW   = $clog2(SCREEN_COLUMNS);
  localparam int unsigned RW   = $clog2(SCREEN_ROWS);
  localparam int unsigned AW   = $clog2(CellCount);
  localparam int unsigned CellW = CharW + ColorW;
  localparam int unsigned CWX  = (CW > OutColW) ? CW : OutColW;
  localparam int unsigned RWX  = (RW > OutRowW) ? RW : OutRowW;
  localparam int unsigned IXW  = ((AW > IndexW) ? AW : IndexW) + 1;

  logic [CellW-1:0] mem [CellCount];

  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [AW-1:0]    cnt_q;
  logic             pend_q;
  logic [AW-1:0]    pend_addr_q;
  logic [CellW-1:0] rdata_q;
  logic             done_q;
  logic             rd_hit_q;
  logic             scrolled_q;

  logic             col_last, row_last, newline, row_adv;
  logic [AW-1:0]    cur_addr;
  logic [IXW-1:0]   idx_x;
  logic             idx_hit;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wa;
  logic [CellW-1:0] wd;
  logic [CWX-1:0]   col_x;
  logic [RWX-1:0]   row_x;

  // Work out where the cursor goes
  assign col_last = (col_q == CW'(SCREEN_COLUMNS - 1));
  assign row_last = (row_q == RW'(SCREEN_ROWS - 1));
  assign newline  = (char_code_i == NewlineCode);
  assign row_adv  = newline | col_last;
  assign cur_addr = AW'(32'(row_q) * SCREEN_COLUMNS) + AW'(col_q);

  assign status_o.scroll_need   = row_adv & row_last;
  assign status_o.cnt_copy_last = (cnt_q == AW'(CopyCount - 1));
  assign status_o.cnt_cell_last = (cnt_q == AW'(CellCount - 1));

  // Range check the read index
  assign idx_x   = IXW'(read_index_i);
  assign idx_hit = (idx_x < IXW'(CellCount));

  // Read port: item reads and scroll copy reads
  assign rd_en   = cmd_i.accept_read | cmd_i.copy_rd;
  assign rd_addr = cmd_i.copy_rd ? (cnt_q + AW'(SCREEN_COLUMNS)) : idx_x[AW-1:0];

  // Write port: pending copy, zero sweep or character put
  always_comb begin
    we = 1'b0;
    wa = cur_addr;
    wd = {text_color_i, char_code_i};
    if (pend_q) begin
      we = 1'b1;
      wa = pend_addr_q;
      wd = rdata_q;
    end else if (cmd_i.zero_wr) begin
      we = 1'b1;
      wa = cnt_q;
      wd = '0;
    end else if (cmd_i.accept_put && !newline) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.copy_rd) begin
      pend_addr_q <= cnt_q;
    end
  end

  // Advance the cursor, the sweep counter and the result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
      rd_hit_q   <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.copy_rd;
      done_q <= cmd_i.accept_read | cmd_i.scroll_done |
                (cmd_i.accept_put & ~status_o.scroll_need);
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.copy_rd || cmd_i.zero_wr) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.accept_read) begin
        rd_hit_q   <= idx_hit;
        scrolled_q <= 1'b0;
      end
      if (cmd_i.accept_put) begin
        rd_hit_q   <= 1'b0;
        scrolled_q <= status_o.scroll_need;
        col_q      <= row_adv ? '0 : col_q + CW'(1);
        if (row_adv && !row_last) begin
          row_q <= row_q + RW'(1);
        end
      end
    end
  end

  // Drive the result ports
  assign col_x        = CWX'(col_q);
  assign row_x        = RWX'(row_q);
  assign done_o       = done_q;
  assign cursor_col_o = col_x[OutColW-1:0];
  assign cursor_row_o = row_x[OutRowW-1:0];
  assign cell_char_o  = rd_hit_q ? rdata_q[CharW-1:0] : '0;
  assign cell_color_o = rd_hit_q ? rdata_q[CellW-1:CharW] : '0;
  assign scrolled_o   = scrolled_q;

  // The single write port is never asked for two writes at once
  a_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(cmd_i.zero_wr || cmd_i.accept_put))
    else $error("write port contention");

  // A scrolling result leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && scrolled_q) |-> (row_last && col_q == '0))
    else $error("cursor misplaced after scroll");

  // The cursor column stays on screen
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < SCREEN_COLUMNS)
    else $error("cursor column off screen");

endmodule

@@ sv/text_console_cursor_scroll_top.sv @@
// Text console with cursor and scroll. Start is taken whenever busy is low;
// one result per item comes out on done_o for exactly one cycle, and the
// receiver cannot stall it. A read or a put that stays on screen gives its
// result in the cycle after it is taken, and such items go back to back. A
// put that moves past the last row scrolls the screen store through its
// single read and single write port: busy stays high while it copies
// SCREEN_COLUMNS*(SCREEN_ROWS-1) cells, drains the last copy and clears the
// SCREEN_COLUMNS cells of the last row, and the result follows. After reset
// the SCREEN_COLUMNS*SCREEN_ROWS cells are swept to zero, one cell a cycle,
// with busy high; colour writes on the register port are taken at any time.
module text_console_cursor_scroll_top import tccs_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DefColumns,
  parameter int unsigned SCREEN_ROWS    = DefRows
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               req_type_i,
  input  logic [CharW-1:0]   char_code_i,
  input  logic [IndexW-1:0]  read_index_i,
  output logic               done_o,
  output logic [OutColW-1:0] cursor_col_o,
  output logic [OutRowW-1:0] cursor_row_o,
  output logic [CharW-1:0]   cell_char_o,
  output logic [ColorW-1:0]  cell_color_o,
  output logic               scrolled_o
);

  logic [ColorW-1:0] text_color_q;
  cmd_t              cmd;
  status_t           status;

  // Hold the colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= ColorDefault;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegTextColor) begin
      text_color_q <= pwdata[ColorW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTextColor) ? 32'(text_color_q) : '0;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  tccs_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .text_color_i (text_color_q),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .done_o       (done_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o),
    .scrolled_o   (scrolled_o)
  );

endmodule
